### src/bmhq_pkg.sv
// bmhq_pkg: shared types, codes and constants of the binary min-heap queue.
// Used by every module under src but bmhq_ram; depends on nothing.
package bmhq_pkg;

  localparam int unsigned HEAP_DEPTH = 1024;   // default store depth
  localparam int unsigned COUNT_W    = 10;     // held count and capacity width
  localparam int unsigned INDEX_W    = COUNT_W + 1;  // room for child index 2*i+1
  localparam int unsigned COUNT_MAX  = (1 << COUNT_W) - 1;
  localparam int unsigned ENTRY_W    = 64;
  localparam logic [COUNT_W-1:0] CAP_RESET = COUNT_W'(4);

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_APPEND = 2'd1,
    FN_BUILD  = 2'd2,
    FN_POP    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [31:0] weight;
    logic [15:0] from_vertex;
    logic [15:0] to_vertex;
  } entry_t;

  typedef struct packed {
    func_e       func;
    logic [31:0] weight_in;
    logic [15:0] from_vertex_in;
    logic [15:0] to_vertex_in;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [31:0]        weight_out;
    logic [15:0]        from_vertex_out;
    logic [15:0]        to_vertex_out;
    logic [COUNT_W-1:0] entry_count;
  } out_item_t;

  // Datapath commands, one per cycle.
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,         // latch accepted word
    DP_FULL,         // mark result full
    DP_EMPTY,        // mark result empty
    DP_APPEND,       // write entry at count+1, count++
    DP_INS_START,    // count++, hole at new slot, carry entry
    DP_UP_READ,      // read parent of hole
    DP_UP_MOVE,      // parent drops into hole, hole moves up
    DP_PUT_CUR,      // carried entry settles in hole
    DP_POP_RD_ROOT,  // read slot 1
    DP_POP_RD_LAST,  // keep root as result, read last slot
    DP_POP_LOAD,     // carry last entry from root, count--
    DP_BUILD_INIT,   // start index count/2
    DP_BUILD_READ,   // read slot at build index
    DP_BUILD_LOAD,   // carry it, hole at build index
    DP_BUILD_NEXT,   // build index--
    DP_SD_RD_L,      // read left child
    DP_SD_RD_R,      // keep left, read right child
    DP_SD_PICK,      // pick smaller child, left on tie
    DP_SD_MOVE,      // child rises into hole, hole moves down
    DP_PUBLISH       // load result register
  } dp_op_e;

  typedef struct packed {
    func_e func;
    logic  full;        // held count at limit
    logic  empty;       // nothing held
    logic  up_more;     // hole below root
    logic  up_less;     // carried weight < parent weight
    logic  has_left;    // hole has a left child
    logic  sd_less;     // picked child weight < carried weight
    logic  build_more;  // build index not yet zero
  } dp_stat_t;

endpackage

### src/bmhq_ram.sv
// bmhq_ram: generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
module bmhq_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### src/bmhq_dp.sv
// bmhq_dp: heap datapath: store RAM, held count, capacity, hole index,
// carried entry, child pick and result register. Depends on bmhq_pkg, bmhq_ram.
module bmhq_dp #(
  parameter int unsigned HeapDepth = bmhq_pkg::HEAP_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bmhq_pkg::dp_op_e                 op_i,
  output bmhq_pkg::dp_stat_t               stat_o,
  input  bmhq_pkg::in_item_t               in_data_i,
  output bmhq_pkg::out_item_t              out_data_o,
  input  logic                             cfg_we_i,
  input  logic [bmhq_pkg::COUNT_W-1:0]     cfg_data_i
);

  localparam int unsigned CW    = bmhq_pkg::COUNT_W;
  localparam int unsigned IW    = bmhq_pkg::INDEX_W;
  localparam int unsigned AddrW = (HeapDepth > 1) ? $clog2(HeapDepth) : 1;
  localparam int unsigned LimMaxInt =
      (HeapDepth - 1 > bmhq_pkg::COUNT_MAX) ? bmhq_pkg::COUNT_MAX : HeapDepth - 1;
  localparam logic [CW-1:0] LimMax = CW'(LimMaxInt);
  localparam int unsigned ENTRY_W_L = bmhq_pkg::ENTRY_W;

  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        cap_q;
  logic [CW-1:0]        idx_q, idx_d;
  logic [CW-1:0]        n_q, n_d;
  logic [CW-1:0]        bi_q, bi_d;
  logic [CW-1:0]        cidx_q, cidx_d;
  bmhq_pkg::entry_t     entry_q, entry_d;
  bmhq_pkg::entry_t     cur_q, cur_d;
  bmhq_pkg::entry_t     child_q, child_d;
  bmhq_pkg::entry_t     pop_q, pop_d;
  bmhq_pkg::func_e      func_q, func_d;
  bmhq_pkg::status_e    status_q, status_d;
  bmhq_pkg::out_item_t  res_q, res_d;

  bmhq_pkg::entry_t     rdata;
  logic [ENTRY_W_L-1:0] rdata_raw;
  logic                 rd_en, wr_en;
  logic [IW-1:0]        rd_idx, wr_idx;
  bmhq_pkg::entry_t     wr_data;
  logic [CW-1:0]        limit;
  logic [IW-1:0]        left_idx, right_idx;
  logic                 has_right;

  assign limit     = (cap_q < LimMax) ? cap_q : LimMax;
  assign left_idx  = {idx_q, 1'b0};
  assign right_idx = {idx_q, 1'b1};
  assign has_right = right_idx <= {1'b0, n_q};
  assign rdata     = bmhq_pkg::entry_t'(rdata_raw);

  assign stat_o.func       = func_q;
  assign stat_o.full       = count_q >= limit;
  assign stat_o.empty      = count_q == '0;
  assign stat_o.up_more    = idx_q > CW'(1);
  assign stat_o.up_less    = cur_q.weight < rdata.weight;
  assign stat_o.has_left   = left_idx <= {1'b0, n_q};
  assign stat_o.sd_less    = child_q.weight < cur_q.weight;
  assign stat_o.build_more = bi_q != '0;

  // RAM port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_idx  = '0;
    wr_en   = 1'b0;
    wr_idx  = {1'b0, idx_q};
    wr_data = cur_q;
    unique case (op_i)
      bmhq_pkg::DP_UP_READ: begin
        rd_en  = 1'b1;
        rd_idx = {2'b00, idx_q[CW-1:1]};
      end
      bmhq_pkg::DP_POP_RD_ROOT: begin
        rd_en  = 1'b1;
        rd_idx = IW'(1);
      end
      bmhq_pkg::DP_POP_RD_LAST: begin
        rd_en  = 1'b1;
        rd_idx = {1'b0, count_q};
      end
      bmhq_pkg::DP_BUILD_READ: begin
        rd_en  = 1'b1;
        rd_idx = {1'b0, bi_q};
      end
      bmhq_pkg::DP_SD_RD_L: begin
        rd_en  = 1'b1;
        rd_idx = left_idx;
      end
      bmhq_pkg::DP_SD_RD_R: begin
        rd_en  = 1'b1;
        rd_idx = right_idx;
      end
      bmhq_pkg::DP_APPEND: begin
        wr_en   = 1'b1;
        wr_idx  = {1'b0, count_q} + IW'(1);
        wr_data = entry_q;
      end
      bmhq_pkg::DP_UP_MOVE: begin
        wr_en   = 1'b1;
        wr_data = rdata;
      end
      bmhq_pkg::DP_PUT_CUR: begin
        wr_en   = 1'b1;
      end
      bmhq_pkg::DP_SD_MOVE: begin
        wr_en   = 1'b1;
        wr_data = child_q;
      end
      default: ;
    endcase
  end

  bmhq_ram #(
    .Width(ENTRY_W_L),
    .Depth(HeapDepth)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(AddrW'(wr_idx)),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(AddrW'(rd_idx)),
    .rd_data_o(rdata_raw)
  );

  always_comb begin
    count_d  = count_q;
    idx_d    = idx_q;
    n_d      = n_q;
    bi_d     = bi_q;
    cidx_d   = cidx_q;
    entry_d  = entry_q;
    cur_d    = cur_q;
    child_d  = child_q;
    pop_d    = pop_q;
    func_d   = func_q;
    status_d = status_q;
    res_d    = res_q;
    unique case (op_i)
      bmhq_pkg::DP_LOAD: begin
        func_d               = in_data_i.func;
        entry_d.weight       = in_data_i.weight_in;
        entry_d.from_vertex  = in_data_i.from_vertex_in;
        entry_d.to_vertex    = in_data_i.to_vertex_in;
        pop_d                = '0;
        status_d             = bmhq_pkg::ST_OK;
      end
      bmhq_pkg::DP_FULL:  status_d = bmhq_pkg::ST_FULL;
      bmhq_pkg::DP_EMPTY: status_d = bmhq_pkg::ST_EMPTY;
      bmhq_pkg::DP_APPEND: count_d = count_q + CW'(1);
      bmhq_pkg::DP_INS_START: begin
        count_d = count_q + CW'(1);
        idx_d   = count_q + CW'(1);
        cur_d   = entry_q;
      end
      bmhq_pkg::DP_UP_MOVE: idx_d = idx_q >> 1;
      bmhq_pkg::DP_POP_RD_LAST: pop_d = rdata;
      bmhq_pkg::DP_POP_LOAD: begin
        cur_d   = rdata;
        idx_d   = CW'(1);
        count_d = count_q - CW'(1);
        n_d     = count_q - CW'(1);
      end
      bmhq_pkg::DP_BUILD_INIT: begin
        bi_d = count_q >> 1;
        n_d  = count_q;
      end
      bmhq_pkg::DP_BUILD_LOAD: begin
        cur_d = rdata;
        idx_d = bi_q;
      end
      bmhq_pkg::DP_BUILD_NEXT: bi_d = bi_q - CW'(1);
      bmhq_pkg::DP_SD_RD_R: begin
        child_d = rdata;
        cidx_d  = left_idx[CW-1:0];
      end
      bmhq_pkg::DP_SD_PICK: begin
        // right wins only when strictly lighter
        if (has_right && (rdata.weight < child_q.weight)) begin
          child_d = rdata;
          cidx_d  = right_idx[CW-1:0];
        end
      end
      bmhq_pkg::DP_SD_MOVE: idx_d = cidx_q;
      bmhq_pkg::DP_PUBLISH: begin
        res_d.status          = status_q;
        res_d.weight_out      = pop_q.weight;
        res_d.from_vertex_out = pop_q.from_vertex;
        res_d.to_vertex_out   = pop_q.to_vertex;
        res_d.entry_count     = count_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= bmhq_pkg::CAP_RESET;
    end else begin
      count_q <= count_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    n_q      <= n_d;
    bi_q     <= bi_d;
    cidx_q   <= cidx_d;
    entry_q  <= entry_d;
    cur_q    <= cur_d;
    child_q  <= child_d;
    pop_q    <= pop_d;
    func_q   <= func_d;
    status_q <= status_d;
    res_q    <= res_d;
  end

  assign out_data_o = res_q;

endmodule

### src/bmhq_ctrl.sv
// bmhq_ctrl: sequencer of the heap queue; issues one datapath command a cycle
// and runs both handshakes. Depends on bmhq_pkg.
module bmhq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  bmhq_pkg::dp_stat_t  stat_i,
  output bmhq_pkg::dp_op_e    op_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_UP_CHECK,
    S_UP_CMP,
    S_POP_LAST,
    S_POP_LOAD,
    S_BLD_CHECK,
    S_BLD_LOAD,
    S_SD_CHECK,
    S_SD_RD_R,
    S_SD_PICK,
    S_SD_CMP,
    S_SD_END,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    op_o    = bmhq_pkg::DP_NOP;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = bmhq_pkg::DP_LOAD;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (stat_i.func)
          bmhq_pkg::FN_INSERT: begin
            if (stat_i.full) begin
              op_o    = bmhq_pkg::DP_FULL;
              state_d = S_FINISH;
            end else begin
              op_o    = bmhq_pkg::DP_INS_START;
              state_d = S_UP_CHECK;
            end
          end
          bmhq_pkg::FN_APPEND: begin
            op_o    = stat_i.full ? bmhq_pkg::DP_FULL : bmhq_pkg::DP_APPEND;
            state_d = S_FINISH;
          end
          bmhq_pkg::FN_BUILD: begin
            op_o    = bmhq_pkg::DP_BUILD_INIT;
            state_d = S_BLD_CHECK;
          end
          bmhq_pkg::FN_POP: begin
            if (stat_i.empty) begin
              op_o    = bmhq_pkg::DP_EMPTY;
              state_d = S_FINISH;
            end else begin
              op_o    = bmhq_pkg::DP_POP_RD_ROOT;
              state_d = S_POP_LAST;
            end
          end
          default: ;
        endcase
      end
      S_UP_CHECK: begin
        if (stat_i.up_more) begin
          op_o    = bmhq_pkg::DP_UP_READ;
          state_d = S_UP_CMP;
        end else begin
          op_o    = bmhq_pkg::DP_PUT_CUR;
          state_d = S_FINISH;
        end
      end
      S_UP_CMP: begin
        if (stat_i.up_less) begin
          op_o    = bmhq_pkg::DP_UP_MOVE;
          state_d = S_UP_CHECK;
        end else begin
          op_o    = bmhq_pkg::DP_PUT_CUR;
          state_d = S_FINISH;
        end
      end
      S_POP_LAST: begin
        op_o    = bmhq_pkg::DP_POP_RD_LAST;
        state_d = S_POP_LOAD;
      end
      S_POP_LOAD: begin
        op_o    = bmhq_pkg::DP_POP_LOAD;
        state_d = S_SD_CHECK;
      end
      S_BLD_CHECK: begin
        if (stat_i.build_more) begin
          op_o    = bmhq_pkg::DP_BUILD_READ;
          state_d = S_BLD_LOAD;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_BLD_LOAD: begin
        op_o    = bmhq_pkg::DP_BUILD_LOAD;
        state_d = S_SD_CHECK;
      end
      S_SD_CHECK: begin
        if (stat_i.has_left) begin
          op_o    = bmhq_pkg::DP_SD_RD_L;
          state_d = S_SD_RD_R;
        end else begin
          op_o    = bmhq_pkg::DP_PUT_CUR;
          state_d = S_SD_END;
        end
      end
      S_SD_RD_R: begin
        op_o    = bmhq_pkg::DP_SD_RD_R;
        state_d = S_SD_PICK;
      end
      S_SD_PICK: begin
        op_o    = bmhq_pkg::DP_SD_PICK;
        state_d = S_SD_CMP;
      end
      S_SD_CMP: begin
        if (stat_i.sd_less) begin
          op_o    = bmhq_pkg::DP_SD_MOVE;
          state_d = S_SD_CHECK;
        end else begin
          op_o    = bmhq_pkg::DP_PUT_CUR;
          state_d = S_SD_END;
        end
      end
      S_SD_END: begin
        if (stat_i.func == bmhq_pkg::FN_BUILD) begin
          op_o    = bmhq_pkg::DP_BUILD_NEXT;
          state_d = S_BLD_CHECK;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        // wait until the result register can take the new word
        if (slot_free) begin
          op_o    = bmhq_pkg::DP_PUBLISH;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (op_o == bmhq_pkg::DP_PUBLISH) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

### src/binary_min_heap_queue.sv
// Binary min-heap priority queue: one word in, one result word out per
// operation. Append and any full or empty report finish without a heap walk;
// insert walks up the heap from the new slot, while pop and build heap walk
// down it, one compare at a time over the single read port of the entry RAM;
// a result still waiting for the consumer holds the block until it is taken.
// The next word is taken as soon as the previous result is in the output
// register, which holds it until the consumer takes it.
// Capacity is to be written through the config port only while idle; the
// block itself does not enforce this. There is no clearing pass after reset.
module binary_min_heap_queue #(
  parameter int unsigned HeapDepth = bmhq_pkg::HEAP_DEPTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  bmhq_pkg::in_item_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output bmhq_pkg::out_item_t          out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bmhq_pkg::COUNT_W-1:0] cfg_data_i
);

  bmhq_pkg::dp_op_e   op;
  bmhq_pkg::dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  bmhq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .op_o       (op)
  );

  bmhq_dp #(
    .HeapDepth(HeapDepth)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (op),
    .stat_o    (stat),
    .in_data_i (in_data_i),
    .out_data_o(out_data_o),
    .cfg_we_i  (cfg_valid_i && cfg_ready_o),
    .cfg_data_i(cfg_data_i)
  );

endmodule

### src/bmhq_checker.sv
// bmhq_checker: port-level assertions on the heap queue, bound to the top.
// Depends on bmhq_pkg and binary_min_heap_queue.
module bmhq_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input bmhq_pkg::out_item_t          out_data_o
);

  // a result word is held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word dropped or changed while stalled");

  // one word in flight: the port closes right after a word is taken
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while previous word still in work");

  // only a successful pop carries an entry
  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != bmhq_pkg::ST_OK) |->
      (out_data_o.weight_out == '0) && (out_data_o.from_vertex_out == '0) &&
      (out_data_o.to_vertex_out == '0))
    else $error("failed operation reports an entry");

  // an empty pop leaves nothing held
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == bmhq_pkg::ST_EMPTY) |->
      out_data_o.entry_count == '0)
    else $error("empty status with entries held");

endmodule

bind binary_min_heap_queue bmhq_checker u_bmhq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

### dv/tb.sv
// tb: self-checking bench for binary_min_heap_queue, with a heap mirror that predicts every result.
// Drives random ops and capacity writes, with random idling on both sides.
// Depends on src/bmhq_pkg.sv and src/binary_min_heap_queue.sv.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bmhq_pkg::*;

  localparam int unsigned CLK_PERIOD  = 10;
  localparam int unsigned HOLD_CYCLES = 300;     // long receiver hold-off
  localparam int unsigned TAIL_CYCLES = 200;     // quiet time after the last result
  localparam int unsigned MAX_REPORTS = 100;
  localparam longint unsigned TIMEOUT_NS = 64'd50_000_000;

  // Software heap that mirrors the block; one due result per accepted word.
  class heap_mirror;
    entry_t      slots [HEAP_DEPTH];
    int unsigned held;
    int unsigned cap;
    out_item_t   due_results [$];
    int unsigned errors;

    function new();
      held   = 0;
      cap    = CAP_RESET;
      errors = 0;
    endfunction

    function void set_capacity(logic [COUNT_W-1:0] v);
      cap = v;
    endfunction

    function int unsigned room_limit();
      return (cap < HEAP_DEPTH - 1) ? cap : HEAP_DEPTH - 1;
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      entry_t t;
      t        = slots[a];
      slots[a] = slots[b];
      slots[b] = t;
    endfunction

    function void sink(int unsigned idx, int unsigned n);
      int unsigned c;
      while (idx * 2 <= n) begin
        c = idx * 2;
        // left child wins a tie
        if (c + 1 <= n && slots[c+1].weight < slots[c].weight) c++;
        if (slots[c].weight < slots[idx].weight) begin
          swap_slots(c, idx);
          idx = c;
        end else begin
          break;
        end
      end
    endfunction

    function void note_word(in_item_t w);
      out_item_t   r;
      int unsigned idx;
      int          i;
      r        = '0;
      r.status = ST_OK;
      case (w.func)
        FN_INSERT, FN_APPEND: begin
          if (held >= room_limit()) begin
            r.status = ST_FULL;
          end else begin
            held++;
            slots[held].weight      = w.weight_in;
            slots[held].from_vertex = w.from_vertex_in;
            slots[held].to_vertex   = w.to_vertex_in;
            if (w.func == FN_INSERT) begin
              idx = held;
              while (idx > 1 && slots[idx].weight < slots[idx/2].weight) begin
                swap_slots(idx, idx / 2);
                idx = idx / 2;
              end
            end
          end
        end
        FN_BUILD: begin
          for (i = int'(held / 2); i >= 1; i--) sink(i, held);
        end
        default: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.weight_out      = slots[1].weight;
            r.from_vertex_out = slots[1].from_vertex;
            r.to_vertex_out   = slots[1].to_vertex;
            slots[1]          = slots[held];
            held--;
            sink(1, held);
          end
        end
      endcase
      r.entry_count = COUNT_W'(held);
      due_results.push_back(r);
    endfunction

    function void compare(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= MAX_REPORTS) $error("%s: expected %0h, got %0h", field, want, got);
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) $error("result word with no expectation waiting");
        return;
      end
      want = due_results.pop_front();
      compare("status", want.status, got.status);
      compare("weight_out", want.weight_out, got.weight_out);
      compare("from_vertex_out", want.from_vertex_out, got.from_vertex_out);
      compare("to_vertex_out", want.to_vertex_out, got.to_vertex_out);
      compare("entry_count", want.entry_count, got.entry_count);
    endfunction

    function int unsigned outstanding();
      return due_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [COUNT_W-1:0] cfg_data;

  heap_mirror  mirror = new();
  int unsigned words_sent = 0;
  int unsigned calm_left = 0;
  bit          long_hold = 1'b0;

  binary_min_heap_queue DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [31:0] pick_weight();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return 32'($urandom_range(0, 7));   // small keys, lots of ties
    if (r < 6) begin
      case ($urandom_range(0, 3))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h7FFF_FFFF;
        default: return 32'h8000_0000;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_vertex();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Offer one word, hold it until taken, then maybe idle.
  task automatic put_op(func_e f, logic [31:0] w, logic [15:0] fv, logic [15:0] tv);
    in_item_t    word;
    int unsigned gap;
    word.func           = f;
    word.weight_in      = w;
    word.from_vertex_in = fv;
    word.to_vertex_in   = tv;
    in_valid <= 1'b1;
    in_data  <= word;
    do @(posedge clk); while (!in_ready);
    mirror.note_word(word);
    words_sent++;
    if (calm_left > 0) calm_left--;
    else if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(20, 60);
    gap = (calm_left > 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic add_random(func_e f);
    put_op(f, pick_weight(), pick_vertex(), pick_vertex());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (mirror.outstanding() != 0) @(posedge clk);
  endtask

  // Capacity is only written with nothing in flight.
  task automatic write_capacity(logic [COUNT_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    mirror.set_capacity(v);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(logic [COUNT_W-1:0] cap_value, int unsigned quota, bit hold_off);
    int unsigned start;
    int unsigned k;
    int unsigned r;
    write_capacity(cap_value);
    start = words_sent;
    if (hold_off) long_hold = 1'b1;
    while (words_sent - start < quota) begin
      r = $urandom_range(0, 99);
      k = $urandom_range(1, 12);
      if (r < 35) begin
        repeat (k) add_random(FN_INSERT);
        repeat (k + $urandom_range(0, 2)) add_random(FN_POP);
      end else if (r < 60) begin
        repeat (k) add_random(FN_APPEND);
        add_random(FN_BUILD);
        repeat ($urandom_range(1, k + 1)) add_random(FN_POP);
      end else if (r < 70 && mirror.room_limit() <= 48) begin
        // fill to the limit, one past it, heapify, then empty it and pop once more
        while (mirror.held < mirror.room_limit()) add_random(FN_APPEND);
        add_random(FN_APPEND);
        add_random(FN_BUILD);
        while (mirror.held > 0) add_random(FN_POP);
        add_random(FN_POP);
      end else begin
        repeat (8) add_random(func_e'($urandom_range(0, 3)));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) mirror.check_result(out_data);
  end

  // Receiver: random stalls, calm stretches, and long hold-offs on request.
  initial begin
    int unsigned n;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 4);
      repeat (n) @(posedge clk);
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb failed");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset capacity of four
    put_op(FN_POP,    32'h0,         16'h0,    16'h0);     // pop on empty
    put_op(FN_BUILD,  32'h0,         16'h0,    16'h0);     // build on nothing
    put_op(FN_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    put_op(FN_BUILD,  32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);  // build on one entry
    put_op(FN_INSERT, 32'd5,         16'h0000, 16'h0000);
    put_op(FN_INSERT, 32'd5,         16'h0001, 16'h0002);  // equal keys
    put_op(FN_INSERT, 32'h0,         16'h1234, 16'h5678);
    put_op(FN_INSERT, 32'd3,         16'hAAAA, 16'h5555);  // full
    put_op(FN_APPEND, 32'd1,         16'h5555, 16'hAAAA);  // full
    put_op(FN_POP,    32'h0,         16'h0,    16'h0);
    put_op(FN_POP,    32'h0,         16'h0,    16'h0);
    put_op(FN_APPEND, 32'd9,         16'h00FF, 16'hFF00);
    put_op(FN_APPEND, 32'd1,         16'hFF00, 16'h00FF);
    put_op(FN_BUILD,  32'h0,         16'h0,    16'h0);
    repeat (5) put_op(FN_POP, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);  // last one hits empty
    put_op(FN_APPEND, 32'd9,         16'h0009, 16'h0009);
    put_op(FN_APPEND, 32'd8,         16'h0008, 16'h0008);
    put_op(FN_APPEND, 32'd7,         16'h0007, 16'h0007);
    put_op(FN_INSERT, 32'd7,         16'hAAAA, 16'h5555);

    // first phase lowers the capacity below the held count
    run_phase(COUNT_W'(2), 120, 1'b0);
    run_phase('0, 60, 1'b0);
    run_phase(COUNT_W'(1), 100, 1'b0);
    run_phase(COUNT_W'(COUNT_MAX), 150, 1'b1);
    run_phase(COUNT_W'(5), 120, 1'b0);
    run_phase(COUNT_W'(40), 150, 1'b0);
    run_phase(COUNT_W'($urandom_range(1, COUNT_MAX)), 150, 1'b0);
    run_phase(COUNT_W'(31), 150, 1'b1);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mirror.errors == 0 && mirror.outstanding() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
